[design/tss_pkg.sv]
// Shared types and constants for the tick scheduler with semaphores.
// Used by the controller, the datapath and the top level.
package tss_pkg;

   localparam int NUM_TASKS_DEFAULT      = 8;
   localparam int NUM_SEMAPHORES_DEFAULT = 8;
   localparam int SLEEP_WIDTH_DEFAULT    = 16;

   localparam int MODE_W   = 2;
   localparam int SEM_IN_W = 3;
   localparam int TICKS_W  = 16;
   localparam int TASK_OUT_W = 3;
   localparam int CSR_W    = 64;
   localparam int CSR_IDX_W = 1;
   localparam int SLICE_W  = 8;
   localparam int COUNT_W  = 10;

   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_P     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_V     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_PRIORITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEM_INIT = 1'd1;

   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 10'sd511;
   localparam logic signed [COUNT_W-1:0] COUNT_MIN = -10'sd512;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVENT,
      ST_WAKE,
      ST_AGE,
      ST_SCAN,
      ST_CHECK,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;      // take the request word
      logic slice_dec;    // consume one slice of the running task
      logic sleep_write;  // park the running task
      logic sem_p;        // P: count down, block and enqueue when negative
      logic sem_v;        // V: count up, dequeue when waiters remain
      logic wake_apply;   // release the dequeued task
      logic age_all;      // decrement every nonzero sleep count
      logic scan_clear;   // restart the scan at task 0
      logic scan_step;    // compare one task
      logic refill_all;   // refill empty slices from priorities
      logic commit_pick;  // make the best task the running one
      logic out_load;     // load the result register
      logic out_none;     // none_ready value for out_load
   } ctrl_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              sem_ok;
      logic              p_blocks;
      logic              v_wakes;
      logic              idx_last;
      logic              best_zero;
      logic              out_busy;
   } ctrl_status_type;

endpackage

[design/tss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tss_ctrl.sv]
// Sequencer for the scheduler: decodes one event and steps the scan.
// Depends on tss_pkg.
module tss_ctrl import tss_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      pass_ff, pass_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pass_in   = pass_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               pass_in     = 1'b0;
               state_in    = ST_EVENT;
            end
         end
         ST_EVENT: begin
            state_in = ST_OUT;
            case (status.mode)
               MODE_TICK: begin
                  cmd.slice_dec = 1'b1;
                  state_in      = ST_AGE;
               end
               MODE_SLEEP: begin
                  cmd.sleep_write = 1'b1;
                  state_in        = ST_AGE;
               end
               MODE_P: begin
                  if (status.sem_ok) begin
                     cmd.sem_p = 1'b1;
                     if (status.p_blocks) begin
                        state_in = ST_AGE;
                     end
                  end
               end
               default: begin
                  if (status.sem_ok) begin
                     cmd.sem_v = 1'b1;
                     if (status.v_wakes) begin
                        state_in = ST_WAKE;
                     end
                  end
               end
            endcase
         end
         ST_WAKE: begin
            cmd.wake_apply = 1'b1;
            state_in       = ST_OUT;
         end
         ST_AGE: begin
            cmd.age_all    = 1'b1;
            cmd.scan_clear = 1'b1;
            pass_in        = 1'b0;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.idx_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.best_zero) begin
               cmd.commit_pick = 1'b1;
               state_in        = ST_OUT;
            end else if (!pass_ff) begin
               // refill empty slices, then scan once more
               cmd.refill_all = 1'b1;
               cmd.scan_clear = 1'b1;
               pass_in        = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            cmd.out_none = status.best_zero && pass_ff;
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[design/tss_datapath.sv]
// Task tables, semaphore counts, wait rings and result register.
// Depends on tss_pkg and tss_ram.
module tss_datapath import tss_pkg::*; #(
   parameter int NUM_TASKS      = NUM_TASKS_DEFAULT,
   parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEFAULT,
   parameter int SLEEP_WIDTH    = SLEEP_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [SEM_IN_W-1:0]   req_sem_index,
   input  logic [TICKS_W-1:0]    req_sleep_ticks,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_write_data,
   input  ctrl_cmd_type          cmd,
   output ctrl_status_type       status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [TASK_OUT_W-1:0] rsp_running_task,
   output logic                  rsp_none_ready,
   output logic                  rsp_caller_blocked,
   output logic                  rsp_woken_valid,
   output logic [TASK_OUT_W-1:0] rsp_woken_task
);

   localparam int TASK_W = $clog2(NUM_TASKS);
   localparam int SEM_W  = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
   localparam int RING_DEPTH = NUM_SEMAPHORES * NUM_TASKS;
   localparam int ADDR_W = $clog2(RING_DEPTH);
   localparam logic [TASK_W-1:0] LAST_TASK = TASK_W'(NUM_TASKS - 1);

   logic [CSR_W-1:0]       priority_ff;
   logic [SLICE_W-1:0]     slice_ff [NUM_TASKS];
   logic [SLEEP_WIDTH-1:0] sleep_ff [NUM_TASKS];
   logic [NUM_TASKS-1:0]   blocked_ff;
   logic [TASK_W-1:0]      current_ff;
   logic signed [COUNT_W-1:0] count_ff [NUM_SEMAPHORES];
   logic [TASK_W-1:0]      head_ff [NUM_SEMAPHORES];
   logic [TASK_W-1:0]      tail_ff [NUM_SEMAPHORES];

   logic [MODE_W-1:0]      mode_ff;
   logic [SEM_W-1:0]       sem_ff;
   logic                   sem_ok_ff;
   logic [SLEEP_WIDTH-1:0] ticks_ff;
   logic [TASK_W-1:0]      idx_ff;
   logic [SLICE_W-1:0]     best_ff;
   logic [TASK_W-1:0]      pick_ff;
   logic                   blk_ff;
   logic                   wv_ff;
   logic [TASK_W-1:0]      wt_ff;

   logic                   out_valid_ff;
   logic [TASK_OUT_W-1:0]  out_task_ff;
   logic                   out_none_ff;
   logic                   out_blk_ff;
   logic                   out_wv_ff;
   logic [TASK_OUT_W-1:0]  out_wt_ff;

   logic signed [COUNT_W-1:0] count_cur;
   logic signed [COUNT_W-1:0] count_dec;
   logic signed [COUNT_W-1:0] count_inc;
   logic [TASK_W-1:0]      head_cur;
   logic [TASK_W-1:0]      tail_cur;
   logic [TASK_W-1:0]      head_next;
   logic [TASK_W-1:0]      tail_next;
   logic [ADDR_W-1:0]      sem_base;
   logic [TASK_W-1:0]      ring_rd_data;
   logic                   idx_ready;
   logic                   ring_wr;
   logic                   ring_rd;

   assign count_cur = count_ff[sem_ff];
   assign count_dec = (count_cur != COUNT_MIN) ? count_cur - 10'sd1 : count_cur;
   assign count_inc = (count_cur != COUNT_MAX) ? count_cur + 10'sd1 : count_cur;
   assign head_cur  = head_ff[sem_ff];
   assign tail_cur  = tail_ff[sem_ff];
   assign head_next = (head_cur == LAST_TASK) ? '0 : head_cur + 1'b1;
   assign tail_next = (tail_cur == LAST_TASK) ? '0 : tail_cur + 1'b1;
   assign sem_base  = ADDR_W'(sem_ff) * ADDR_W'(NUM_TASKS);
   assign idx_ready = (sleep_ff[idx_ff] == '0) && !blocked_ff[idx_ff];

   assign ring_wr = cmd.sem_p && count_dec[COUNT_W-1];
   assign ring_rd = cmd.sem_v && (count_inc[COUNT_W-1] || count_inc == '0);

   tss_ram #(
      .WIDTH (TASK_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (sem_base + ADDR_W'(tail_cur)),
      .wr_data (current_ff),
      .rd_en   (ring_rd),
      .rd_addr (sem_base + ADDR_W'(head_cur)),
      .rd_data (ring_rd_data)
   );

   // Event word and scan registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff   <= req_mode;
         sem_ff    <= req_sem_index[SEM_W-1:0];
         sem_ok_ff <= {1'b0, req_sem_index} < (SEM_IN_W + 1)'(NUM_SEMAPHORES);
         ticks_ff  <= SLEEP_WIDTH'(req_sleep_ticks);
         idx_ff    <= current_ff;
         blk_ff    <= 1'b0;
         wv_ff     <= 1'b0;
         wt_ff     <= '0;
         best_ff   <= '0;
      end
      if (cmd.scan_clear) begin
         idx_ff  <= '0;
         best_ff <= '0;
      end
      if (cmd.scan_step) begin
         idx_ff <= (idx_ff == LAST_TASK) ? '0 : idx_ff + 1'b1;
         if (idx_ready && slice_ff[idx_ff] > best_ff) begin
            best_ff <= slice_ff[idx_ff];
            pick_ff <= idx_ff;
         end
      end
      if (ring_wr) begin
         blk_ff <= 1'b1;
      end
      if (ring_rd) begin
         wv_ff <= 1'b1;
      end
      if (cmd.wake_apply) begin
         wt_ff <= ring_rd_data;
      end
   end

   // Task tables and semaphore state.
   always_ff @(posedge clock) begin
      if (reset) begin
         priority_ff <= '0;
         current_ff  <= '0;
         blocked_ff  <= '0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            slice_ff[i] <= '0;
            sleep_ff[i] <= '0;
         end
         for (int s = 0; s < NUM_SEMAPHORES; s++) begin
            count_ff[s] <= '0;
            head_ff[s]  <= '0;
            tail_ff[s]  <= '0;
         end
      end else begin
         if (csr_write_enable && csr_index == CSR_PRIORITY) begin
            priority_ff <= csr_write_data;
         end
         if (csr_write_enable && csr_index == CSR_SEM_INIT) begin
            for (int s = 0; s < NUM_SEMAPHORES; s++) begin
               count_ff[s] <= COUNT_W'(csr_write_data[8*s +: 8]);
            end
         end
         if (cmd.slice_dec && slice_ff[idx_ff] != '0) begin
            slice_ff[idx_ff] <= slice_ff[idx_ff] - 1'b1;
         end
         if (cmd.sleep_write) begin
            sleep_ff[idx_ff] <= ticks_ff;
         end
         for (int i = 0; i < NUM_TASKS; i++) begin
            if (cmd.age_all && sleep_ff[i] != '0) begin
               sleep_ff[i] <= sleep_ff[i] - 1'b1;
            end
            if (cmd.refill_all && slice_ff[i] == '0) begin
               slice_ff[i] <= priority_ff[8*i +: 8];
            end
         end
         if (cmd.sem_p) begin
            count_ff[sem_ff] <= count_dec;
         end
         if (cmd.sem_v) begin
            count_ff[sem_ff] <= count_inc;
         end
         if (ring_wr) begin
            blocked_ff[current_ff] <= 1'b1;
            tail_ff[sem_ff]        <= tail_next;
         end
         if (ring_rd) begin
            head_ff[sem_ff] <= head_next;
         end
         if (cmd.wake_apply) begin
            blocked_ff[ring_rd_data] <= 1'b0;
         end
         if (cmd.commit_pick) begin
            current_ff <= pick_ff;
         end
      end
   end

   // Result register: hold while stalled, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_task_ff <= TASK_OUT_W'(current_ff);
         out_none_ff <= cmd.out_none;
         out_blk_ff  <= blk_ff;
         out_wv_ff   <= wv_ff;
         out_wt_ff   <= TASK_OUT_W'(wt_ff);
      end
   end

   assign status.mode      = mode_ff;
   assign status.sem_ok    = sem_ok_ff;
   assign status.p_blocks  = count_dec[COUNT_W-1];
   assign status.v_wakes   = count_inc[COUNT_W-1] || count_inc == '0;
   assign status.idx_last  = idx_ff == LAST_TASK;
   assign status.best_zero = best_ff == '0;
   assign status.out_busy  = out_valid_ff && rsp_stall;

   assign rsp_valid          = out_valid_ff;
   assign rsp_running_task   = out_task_ff;
   assign rsp_none_ready     = out_none_ff;
   assign rsp_caller_blocked = out_blk_ff;
   assign rsp_woken_valid    = out_wv_ff;
   assign rsp_woken_task     = out_wt_ff;

endmodule

[design/tick_scheduler_with_semaphores_unit.sv]
// Tick scheduler with counting semaphores, one event word in, one result word out.
// A V, a non-blocking P or an out-of-range semaphore goes straight to the result (a V that
// releases a waiter first passes the wake state); tick, sleep and a blocking P first age the
// sleep counts and scan the tasks (one task a cycle), and refill empty slices and scan again
// when no ready task has a slice left. A new word is taken only after the last result is loaded.
// Reset (synchronous) clears all slices, sleep counts, blocks, counts and pointers.
module tick_scheduler_with_semaphores_unit import tss_pkg::*; #(
   parameter int NUM_TASKS      = NUM_TASKS_DEFAULT,
   parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEFAULT,
   parameter int SLEEP_WIDTH    = SLEEP_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [SEM_IN_W-1:0]   req_sem_index,
   input  logic [TICKS_W-1:0]    req_sleep_ticks,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [TASK_OUT_W-1:0] rsp_running_task,
   output logic                  rsp_none_ready,
   output logic                  rsp_caller_blocked,
   output logic                  rsp_woken_valid,
   output logic [TASK_OUT_W-1:0] rsp_woken_task,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_write_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   tss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tss_datapath #(
      .NUM_TASKS      (NUM_TASKS),
      .NUM_SEMAPHORES (NUM_SEMAPHORES),
      .SLEEP_WIDTH    (SLEEP_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_mode           (req_mode),
      .req_sem_index      (req_sem_index),
      .req_sleep_ticks    (req_sleep_ticks),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_running_task   (rsp_running_task),
      .rsp_none_ready     (rsp_none_ready),
      .rsp_caller_blocked (rsp_caller_blocked),
      .rsp_woken_valid    (rsp_woken_valid),
      .rsp_woken_task     (rsp_woken_task)
   );

endmodule

[bench/tb_tick_scheduler_with_semaphores_unit.sv]
// Self-checking bench for tick_scheduler_with_semaphores_unit: random and directed event words,
// predicted results checked by a small scoreboard class. Depends on tss_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_tick_scheduler_with_semaphores_unit;
   import tss_pkg::*;

   typedef struct {
      logic [2:0] running_task;
      logic       none_ready;
      logic       caller_blocked;
      logic       woken_valid;
      logic [2:0] woken_task;
   } sched_result_type;

   class sched_scoreboard;
      logic [63:0]  prio_table;
      int unsigned  slice_left[8];
      int unsigned  sleep_cnt[8];
      bit           blocked[8];
      int unsigned  cur_task;
      int           sem_cnt[8];
      logic [2:0]   ring[8][8];
      bit           ring_written[8][8];
      int unsigned  ring_rd[8];
      int unsigned  ring_wr[8];
      sched_result_type pending[$];
      int           errors;

      function new();
         prio_table = '0;
         cur_task = 0;
         errors = 0;
         for (int i = 0; i < 8; i++) begin
            slice_left[i] = 0;
            sleep_cnt[i] = 0;
            blocked[i] = 0;
            sem_cnt[i] = 0;
            ring_rd[i] = 0;
            ring_wr[i] = 0;
            for (int j = 0; j < 8; j++) ring_written[i][j] = 0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
         if (idx == CSR_PRIORITY) begin
            prio_table = data;
         end else begin
            for (int s = 0; s < 8; s++) sem_cnt[s] = data[8*s +: 8];
         end
      endfunction

      // A V that would release a waiter must find a ring entry that a P wrote.
      function bit v_is_safe(int s);
         int c;
         c = sem_cnt[s];
         if (c < 511) c++;
         if (c <= 0) return ring_written[s][ring_rd[s]];
         return 1;
      endfunction

      function bit pick_task();
         int unsigned best;
         int unsigned pick;
         best = 0;
         pick = cur_task;
         for (int i = 0; i < 8; i++) if (sleep_cnt[i] > 0) sleep_cnt[i]--;
         for (int pass = 0; pass < 2; pass++) begin
            for (int i = 0; i < 8; i++) begin
               if (sleep_cnt[i] == 0 && !blocked[i] && slice_left[i] > best) begin
                  best = slice_left[i];
                  pick = i;
               end
            end
            if (best > 0) break;
            if (pass == 0)
               for (int i = 0; i < 8; i++)
                  if (slice_left[i] == 0) slice_left[i] = prio_table[8*i +: 8];
         end
         if (best == 0) return 1;
         cur_task = pick;
         return 0;
      endfunction

      function void note_word(logic [1:0] mode, logic [2:0] sem, logic [15:0] ticks);
         sched_result_type r;
         int unsigned cur;
         int unsigned t;
         cur = cur_task;
         r.none_ready = 0;
         r.caller_blocked = 0;
         r.woken_valid = 0;
         r.woken_task = 0;
         case (mode)
            MODE_TICK: begin
               if (slice_left[cur] > 0) slice_left[cur]--;
               r.none_ready = pick_task();
            end
            MODE_SLEEP: begin
               sleep_cnt[cur] = ticks;
               r.none_ready = pick_task();
            end
            MODE_P: begin
               if (sem_cnt[sem] > -512) sem_cnt[sem]--;
               if (sem_cnt[sem] < 0) begin
                  blocked[cur] = 1;
                  ring[sem][ring_wr[sem]] = 3'(cur);
                  ring_written[sem][ring_wr[sem]] = 1;
                  ring_wr[sem] = (ring_wr[sem] + 1) % 8;
                  r.caller_blocked = 1;
                  r.none_ready = pick_task();
               end
            end
            default: begin
               if (sem_cnt[sem] < 511) sem_cnt[sem]++;
               if (sem_cnt[sem] <= 0) begin
                  t = ring[sem][ring_rd[sem]];
                  blocked[t] = 0;
                  ring_rd[sem] = (ring_rd[sem] + 1) % 8;
                  r.woken_valid = 1;
                  r.woken_task = 3'(t);
               end
            end
         endcase
         r.running_task = 3'(cur_task);
         pending.push_back(r);
      endfunction

      function void check_result(sched_result_type got);
         sched_result_type exp_r;
         if (pending.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.running_task !== exp_r.running_task) begin
            $error("running_task: expected %0d, got %0d", exp_r.running_task, got.running_task);
            errors++;
         end
         if (got.none_ready !== exp_r.none_ready) begin
            $error("none_ready: expected %0d, got %0d", exp_r.none_ready, got.none_ready);
            errors++;
         end
         if (got.caller_blocked !== exp_r.caller_blocked) begin
            $error("caller_blocked: expected %0d, got %0d",
                   exp_r.caller_blocked, got.caller_blocked);
            errors++;
         end
         if (got.woken_valid !== exp_r.woken_valid) begin
            $error("woken_valid: expected %0d, got %0d", exp_r.woken_valid, got.woken_valid);
            errors++;
         end
         if (got.woken_task !== exp_r.woken_task) begin
            $error("woken_task: expected %0d, got %0d", exp_r.woken_task, got.woken_task);
            errors++;
         end
      endfunction
   endclass

   localparam int IDLE_LIMIT = 4000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [MODE_W-1:0] req_mode = MODE_TICK;
   logic [SEM_IN_W-1:0] req_sem_index = '0;
   logic [TICKS_W-1:0] req_sleep_ticks = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [TASK_OUT_W-1:0] rsp_running_task;
   logic rsp_none_ready;
   logic rsp_caller_blocked;
   logic rsp_woken_valid;
   logic [TASK_OUT_W-1:0] rsp_woken_task;
   logic csr_write_enable = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PRIORITY;
   logic [CSR_W-1:0] csr_write_data = '0;

   sched_scoreboard sched_sb = new();
   bit quiet_phase = 0;
   bit hold_rsp = 0;
   int idle_cycles = 0;

   always #6 clock = ~clock;

   tick_scheduler_with_semaphores_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_sem_index(req_sem_index), .req_sleep_ticks(req_sleep_ticks),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_running_task(rsp_running_task),
      .rsp_none_ready(rsp_none_ready), .rsp_caller_blocked(rsp_caller_blocked),
      .rsp_woken_valid(rsp_woken_valid), .rsp_woken_task(rsp_woken_task),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Watchdog: end the run when no word moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_tick_scheduler_with_semaphores_unit: FAIL");
         $finish;
      end
   end

   // Result side: random stall before each word outside the quiet phase, one long hold on request.
   initial begin
      int n;
      sched_result_type got;
      @(negedge reset);
      forever begin
         n = quiet_phase ? 0 : $urandom_range(0, 9);
         if (hold_rsp) begin
            n = 300;
            hold_rsp = 0;
         end
         if (n > 0) begin
            // stall right away so no word slips through unchecked
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
         do @(posedge clock); while (!rsp_valid);
         got.running_task = rsp_running_task;
         got.none_ready = rsp_none_ready;
         got.caller_blocked = rsp_caller_blocked;
         got.woken_valid = rsp_woken_valid;
         got.woken_task = rsp_woken_task;
         sched_sb.check_result(got);
      end
   end

   task automatic send_word(logic [1:0] mode, logic [2:0] sem, logic [15:0] ticks);
      int gap;
      // swap a V that would pop a never-written ring slot for a tick
      if (mode == MODE_V && !sched_sb.v_is_safe(sem)) mode = MODE_TICK;
      gap = quiet_phase ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= mode;
      req_sem_index <= sem;
      req_sleep_ticks <= ticks;
      do @(posedge clock); while (req_stall);
      sched_sb.note_word(mode, sem, ticks);
   endtask

   task automatic wait_drain();
      req_valid <= 0;
      while (sched_sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
      wait_drain();
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 0;
      sched_sb.write_reg(idx, data);
   endtask

   task automatic random_words(int count);
      int m;
      logic [15:0] ticks;
      for (int k = 0; k < count; k++) begin
         m = $urandom_range(0, 99);
         ticks = ($urandom_range(0, 29) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
         if (m < 35)      send_word(MODE_TICK, 3'($urandom), ticks);
         else if (m < 50) send_word(MODE_SLEEP, 3'($urandom), ticks);
         else if (m < 75) send_word(MODE_P, 3'($urandom), ticks);
         else             send_word(MODE_V, 3'($urandom), ticks);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_csr(CSR_PRIORITY, 64'h0807060504030201);
      write_csr(CSR_SEM_INIT, 64'h0201000100020003);
      // directed: ticks, sleep extremes, P and V on every semaphore
      send_word(MODE_TICK, 3'd0, 16'h0000);
      send_word(MODE_TICK, 3'd7, 16'hFFFF);
      send_word(MODE_SLEEP, 3'd0, 16'h0000);
      send_word(MODE_SLEEP, 3'd0, 16'h0003);
      send_word(MODE_SLEEP, 3'd5, 16'hFFFF);
      for (int s = 0; s < 8; s++) send_word(MODE_P, 3'(s), 16'h0000);
      for (int s = 0; s < 8; s++) send_word(MODE_V, 3'(s), 16'h0000);
      random_words(40);

      write_csr(CSR_PRIORITY, '1);
      write_csr(CSR_SEM_INIT, '1);
      quiet_phase = 1;
      random_words(30);
      quiet_phase = 0;

      write_csr(CSR_PRIORITY, '0);
      write_csr(CSR_SEM_INIT, '0);
      random_words(20);

      write_csr(CSR_PRIORITY, {$urandom, $urandom});
      write_csr(CSR_SEM_INIT, {$urandom, $urandom} & 64'h0303030303030303);
      // hold results off while words keep coming, then pause until all are back
      hold_rsp = 1;
      random_words(20);
      wait_drain();
      random_words(30);

      write_csr(CSR_PRIORITY, 64'h0102040810204080);
      write_csr(CSR_SEM_INIT, '0);
      random_words(20);

      // drive one count to its ceiling
      write_csr(CSR_SEM_INIT, 64'h00000000000000FF);
      for (int k = 0; k < 260; k++) send_word(MODE_V, 3'd0, 16'h0000);
      send_word(MODE_P, 3'd0, 16'h0000);

      wait_drain();
      if (sched_sb.errors == 0)
         $display("tb_tick_scheduler_with_semaphores_unit: PASS");
      else
         $display("tb_tick_scheduler_with_semaphores_unit: FAIL");
      $finish;
   end

endmodule
